FILE: rtl/core/lbs_pkg.sv
package lbs_pkg;
  localparam int MAT_ELEMS = 12;
  localparam int WORD_W = 32;
  localparam int SUM_W = 48;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SKIN = 1'b1;

  typedef struct packed {
    logic func;
    logic matrix_select;
    logic [4:0] joint;
    logic [3:0] element;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0] weight;
    logic last_term;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x > 50'sh007fffffffffff) return 48'sh7fffffffffff;
    if (x < -50'sh00800000000000) return 48'sh800000000000;
    return x[47:0];
  endfunction
endpackage

FILE: rtl/core/lbs_ram.sv
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/lbs_mac.sv
module lbs_mac import lbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [63:0] prod_shifted_r
);
  logic signed [65:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    prod_shifted_r <= 64'(prod >>> FRAC_BITS);
  end
endmodule

FILE: rtl/core/linear_blend_skinning.sv
// Channel  | Ports                                   | Direction | Handshake
// input    | start, busy, in_* fields                | in        | start && !busy
// result   | out_valid, out_x, out_y, out_z          | out       | out_valid, one cycle
// A load word is written in its accept cycle and busy stays low. A skin word holds busy
// high through two passes over 12 matrix elements (each a matrix memory read, the shared
// 33x33 multiply and the accumulate), three weight products and the output step; a joint
// out of range goes straight to the output step. The next word can follow once busy falls,
// and a result word, when its last term is set, shows in the cycle in which busy falls.
// Synchronous active-low reset clears the sequencer and the position sums.
// The receiver cannot stall; a result is shown for exactly one cycle.
module linear_blend_skinning import lbs_pkg::*; #(
  parameter int JOINTS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic               in_matrix_select,
  input  logic [4:0]         in_joint,
  input  logic [3:0]         in_element,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [16:0]        in_weight,
  input  logic               in_last_term,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  localparam int DEPTH = JOINTS * MAT_ELEMS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAT  = 2'd1;
  localparam logic [1:0] S_WGT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic pass_r;
  logic [1:0] row_r;
  logic [2:0] col_r;
  logic [1:0] ph_r;
  logic [AW-1:0] base_r;
  logic [16:0] weight_r;
  logic last_r;
  logic signed [31:0] vin_r [3];
  logic signed [31:0] vout_r [3];
  logic signed [63:0] acc_r;
  logic signed [47:0] sum_r [3];
  logic [1:0] k_r;

  logic signed [31:0] bind_q, pose_q, mat_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [AW-1:0] raddr, waddr;
  logic ld_ok, we_b, we_p;
  logic accept;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign ld_ok = accept && in_func == FUNC_LOAD && in_element < 4'(MAT_ELEMS)
                 && 32'(in_joint) < JOINTS;
  assign waddr = AW'(32'(in_joint) * MAT_ELEMS + 32'(in_element));
  assign we_b = ld_ok && !in_matrix_select;
  assign we_p = ld_ok && in_matrix_select;
  assign raddr = AW'(32'(base_r) + 32'(row_r) * 4 + 32'(col_r));

  lbs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_bind (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(bind_q));
  lbs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_pose (
    .clk(clk), .we(we_p), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(pose_q));

  assign mat_q = pass_r ? pose_q : bind_q;
  always_comb begin
    if (state_r == S_WGT) begin
      mul_a = 33'(weight_r);
      mul_b = 33'(vout_r[k_r]);
    end else begin
      mul_a = 33'(mat_q);
      mul_b = (col_r == 3'd3) ? '0 : 33'(vin_r[col_r[1:0]]);
    end
  end

  lbs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .a(mul_a), .b(mul_b), .prod_shifted_r(prod));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_func == FUNC_SKIN) begin
        state_nxt = (32'(in_joint) < JOINTS) ? S_MAT : S_DONE;
      end
      S_MAT: if (pass_r && row_r == 2'd2 && col_r == 3'd3 && ph_r == 2'd2) begin
        state_nxt = S_WGT;
      end
      S_WGT: if (k_r == 2'd2 && ph_r == 2'd1) begin
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Matrix phase: phase 0 issues the read, 1 multiplies, 2 accumulates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) begin
          pass_r <= 1'b0; row_r <= '0; col_r <= '0; ph_r <= '0; k_r <= '0;
          base_r <= AW'(32'(in_joint) * MAT_ELEMS);
          weight_r <= in_weight;
          last_r <= in_last_term;
          vin_r[0] <= in_pos_x; vin_r[1] <= in_pos_y; vin_r[2] <= in_pos_z;
        end
        S_MAT: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (col_r == 3'd3) begin
            if (ph_r == 2'd1) begin
              ph_r <= 2'd2;
            end else begin
              vout_r[row_r] <= sat32(acc_r + 64'(mat_q));
              ph_r <= '0; col_r <= '0;
              if (row_r == 2'd2) begin
                row_r <= '0;
                if (!pass_r) begin
                  pass_r <= 1'b1;
                  vin_r[0] <= vout_r[0]; vin_r[1] <= vout_r[1];
                  vin_r[2] <= sat32(acc_r + 64'(mat_q));
                end
              end else begin
                row_r <= row_r + 2'd1;
              end
            end
          end else if (ph_r == 2'd1) begin
            ph_r <= 2'd2;
          end else begin
            acc_r <= (col_r == 3'd0) ? prod : acc_r + prod;
            col_r <= col_r + 3'd1;
            ph_r <= '0;
          end
        end
        S_WGT: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            sum_r[k_r] <= sat48(50'(sum_r[k_r]) + 50'(prod));
            ph_r <= '0;
            k_r <= k_r + 2'd1;
          end
        end
        S_DONE: if (last_r) begin
          out_valid <= 1'b1;
          out_x <= sat32(64'(sum_r[0]));
          out_y <= sat32(64'(sum_r[1]));
          out_z <= sat32(64'(sum_r[2]));
          for (int i = 0; i < 3; i++) sum_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_DONE) else $error("result outside done");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_LOAD) |=> !busy) else $error("load held block");
endmodule
